// ----- rtl/gfpp_pkg.sv -----
package gfpp_pkg;

	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;
	localparam int DEF_FRAC_BITS  = 16;

	localparam int RELAX_W  = 18;
	localparam int PSCALE_W = 31;

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_STEP  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_WIDTH   = 3'd0;
	localparam logic [2:0] REG_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_SUB     = 3'd2;
	localparam logic [2:0] REG_RELAX   = 3'd3;
	localparam logic [2:0] REG_GRAVITY = 3'd4;
	localparam logic [2:0] REG_PSCALE  = 3'd5;

	localparam logic [7:0]  RST_WIDTH   = 8'd128;
	localparam logic [7:0]  RST_HEIGHT  = 8'd128;
	localparam logic [7:0]  RST_SUB     = 8'd40;
	localparam logic [17:0] RST_RELAX   = 18'd124518;
	localparam logic [30:0] RST_PSCALE  = 31'd65536;

	typedef enum logic [21:0] {
		S_CLR   = 22'h000001,
		S_IDLE  = 22'h000002,
		S_RDONE = 22'h000004,
		S_DONE  = 22'h000008,
		S_GRD   = 22'h000010,
		S_GWR   = 22'h000020,
		S_SRD0  = 22'h000040,
		S_SRD1  = 22'h000080,
		S_SRD2  = 22'h000100,
		S_CALC  = 22'h000200,
		S_ABS   = 22'h000400,
		S_MUL0  = 22'h000800,
		S_MUL1  = 22'h001000,
		S_RND   = 22'h002000,
		S_DIV   = 22'h004000,
		S_SAT   = 22'h008000,
		S_MULP  = 22'h010000,
		S_PRND  = 22'h020000,
		S_PSUM  = 22'h040000,
		S_WR0   = 22'h080000,
		S_WR1   = 22'h100000,
		S_WR2   = 22'h200000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) r = 32'sh7fffffff;
		else if (x < -64'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/grid_fluid_pressure_projection_unit.sv -----
// write and read: the result word is posted from a done state, one command in flight at a time
// step: a gravity and pressure-clear pass over all w*h cells, then per sweep and interior
//   cell a read, compute and write sequence, bound by the bit-serial divide by the
//   open-neighbour count and the single read and write port of the velocity memory
// reset: asynchronous, active low; then a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries
//   zeroes both memories, with in_stall high throughout
module grid_fluid_pressure_projection_unit #(
	parameter int MAX_WIDTH  = gfpp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gfpp_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = gfpp_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [13:0]        cell_index,
	input  logic signed [31:0] u_value,
	input  logic signed [31:0] v_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         done_kind,
	output logic signed [31:0] u_out,
	output logic signed [31:0] v_out,
	output logic signed [31:0] pressure_out
);
	import gfpp_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int DIM_W  = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
	localparam int MAG_W  = 35;
	localparam int PROD_W = RELAX_W + MAG_W;
	localparam int T_W    = PROD_W + 1 - FRAC_BITS;
	localparam int DCNT_W = $clog2(T_W + 1);
	localparam int LO_W   = 18;

	// configuration registers
	logic [7:0]                gw_q, gh_q, sub_q;
	logic [RELAX_W-1:0]        relax_q;
	logic signed [31:0]        grav_q;
	logic [PSCALE_W-1:0]       pscale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q     <= RST_WIDTH;
			gh_q     <= RST_HEIGHT;
			sub_q    <= RST_SUB;
			relax_q  <= RST_RELAX;
			grav_q   <= '0;
			pscale_q <= RST_PSCALE;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WIDTH:   gw_q     <= cfg_data[7:0];
				REG_HEIGHT:  gh_q     <= cfg_data[7:0];
				REG_SUB:     sub_q    <= cfg_data[7:0];
				REG_RELAX:   relax_q  <= cfg_data[RELAX_W-1:0];
				REG_GRAVITY: grav_q   <= cfg_data;
				REG_PSCALE:  pscale_q <= cfg_data[PSCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped grid size in use
	logic [DIM_W-1:0]  w, h;
	logic [ADDR_W:0]   cells;
	always_comb begin
		if (int'(gw_q) < 3) w = DIM_W'(3);
		else if (int'(gw_q) > MAX_WIDTH) w = DIM_W'(MAX_WIDTH);
		else w = DIM_W'(gw_q);
		if (int'(gh_q) < 3) h = DIM_W'(3);
		else if (int'(gh_q) > MAX_HEIGHT) h = DIM_W'(MAX_HEIGHT);
		else h = DIM_W'(gh_q);
		cells = (ADDR_W+1)'(w) * (ADDR_W+1)'(h);
	end

	// control state
	state_t             state_q;
	logic [ADDR_W-1:0]  c_q;
	logic [DIM_W-1:0]   i_q, j_q;
	logic [7:0]         n_q;
	logic [1:0]         cmd_q;
	logic               inside_q;
	logic [DCNT_W-1:0]  dcnt_q;

	// datapath registers
	logic [63:0]               cw_q, rw_q, uw_q;
	logic signed [33:0]        div_q;
	logic                      neg_q;
	logic [MAG_W-1:0]          mag_q;
	logic [PROD_W-1:0]         prod_q;
	logic [T_W-1:0]            quo_q;
	logic [2:0]                rem_q;
	logic signed [31:0]        corr_q;
	logic signed [63:0]        pp_q, pq_q;
	logic signed [31:0]        pnew_q;

	// memories
	logic [63:0] vel_mem [DEPTH];
	logic [31:0] pres_mem [DEPTH];
	logic              vrd_en, vwr_en, prd_en, pwr_en;
	logic [ADDR_W-1:0] vrd_addr, vwr_addr, prd_addr, pwr_addr;
	logic [63:0]       vwr_data, vrd_q;
	logic [31:0]       pwr_data, prd_q;

	always_ff @(posedge clk) begin
		if (vwr_en) vel_mem[vwr_addr] <= vwr_data;
		if (vrd_en) vrd_q <= vel_mem[vrd_addr];
		if (pwr_en) pres_mem[pwr_addr] <= pwr_data;
		if (prd_en) prd_q <= pres_mem[prd_addr];
	end

	// neighbour flags of the current cell
	logic       sl, sr, sd, su;
	logic [2:0] s;
	logic       gcell;
	logic       in_acc;
	logic [ADDR_W-1:0] in_addr;
	logic       in_inside;
	always_comb begin
		sl = int'(i_q) >= 2;
		sr = int'(i_q) + 3 <= int'(w);
		sd = int'(j_q) >= 2;
		su = int'(j_q) + 3 <= int'(h);
		s  = 3'(sl) + 3'(sr) + 3'(sd) + 3'(su);
		gcell = int'(j_q) >= 2 && int'(j_q) + 2 <= int'(h)
			&& int'(i_q) >= 1 && int'(i_q) + 2 <= int'(w);
		in_acc    = in_valid && !in_stall;
		in_addr   = ADDR_W'(cell_index);
		in_inside = int'(cell_index) < int'(cells);
	end

	assign in_stall = state_q != S_IDLE;

	// memory port steering
	always_comb begin
		vrd_en = 1'b0; vwr_en = 1'b0; prd_en = 1'b0; pwr_en = 1'b0;
		vrd_addr = c_q; vwr_addr = c_q; prd_addr = c_q; pwr_addr = c_q;
		vwr_data = '0; pwr_data = '0;
		case (state_q)
			S_CLR: begin
				vwr_en = 1'b1;
				pwr_en = 1'b1;
			end
			S_IDLE: begin
				// host commands go straight to the memories
				vrd_addr = in_addr;
				prd_addr = in_addr;
				vwr_addr = in_addr;
				vwr_data = {u_value, v_value};
				vrd_en = in_acc && command == CMD_READ;
				prd_en = vrd_en;
				vwr_en = in_acc && command == CMD_WRITE && in_inside;
			end
			S_GRD: begin
				vrd_en = 1'b1;
				pwr_en = 1'b1;
			end
			S_GWR: begin
				vwr_en   = gcell;
				vwr_data = {vrd_q[63:32],
					sat32(64'(signed'(vrd_q[31:0])) + 64'(grav_q))};
			end
			S_SRD0: begin
				vrd_en = s != 3'd0;
				prd_en = vrd_en;
			end
			S_SRD1: begin
				vrd_en   = 1'b1;
				vrd_addr = c_q + ADDR_W'(1);
			end
			S_SRD2: begin
				vrd_en   = 1'b1;
				vrd_addr = c_q + ADDR_W'(w);
			end
			S_WR0: begin
				// own faces and pressure
				vwr_en = 1'b1;
				vwr_data[63:32] = sl ? sat32(64'(signed'(cw_q[63:32])) + 64'(corr_q))
					: cw_q[63:32];
				vwr_data[31:0]  = sd ? sat32(64'(signed'(cw_q[31:0])) + 64'(corr_q))
					: cw_q[31:0];
				pwr_en   = 1'b1;
				pwr_data = pnew_q;
			end
			S_WR1: begin
				vwr_en   = 1'b1;
				vwr_addr = c_q + ADDR_W'(1);
				vwr_data = {sr ? sat32(64'(signed'(rw_q[63:32])) - 64'(corr_q))
					: rw_q[63:32], rw_q[31:0]};
			end
			S_WR2: begin
				// an isolated cell is skipped and writes nothing
				vwr_en   = s != 3'd0;
				vwr_addr = c_q + ADDR_W'(w);
				vwr_data = {uw_q[63:32], su ? sat32(64'(signed'(uw_q[31:0])) - 64'(corr_q))
					: uw_q[31:0]};
			end
			default: ;
		endcase
	end

	// end-of-sweep-cell bookkeeping
	logic last_col, last_row, last_sweep;
	always_comb begin
		last_col   = int'(i_q) + 2 == int'(w);
		last_row   = int'(j_q) + 2 == int'(h);
		last_sweep = n_q + 8'd1 == sub_q;
	end

	logic [PROD_W-1:0] t_sum;
	logic [3:0]        rsh;
	logic              ge;
	logic [63:0]       pmag, pqm;
	always_comb begin
		t_sum = prod_q + (PROD_W'(s) << (FRAC_BITS - 1));
		rsh   = {rem_q, quo_q[T_W-1]};
		ge    = rsh >= {1'b0, s};
		pmag  = pp_q[63] ? 64'(-pp_q) : 64'(pp_q);
		pqm   = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			c_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
			cmd_q     <= '0;
			inside_q  <= 1'b0;
			dcnt_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && !(state_q inside {S_RDONE, S_DONE}))
				out_valid <= 1'b0;
			case (state_q)
				S_CLR: begin
					c_q <= c_q + ADDR_W'(1);
					if (int'(c_q) == DEPTH - 1) begin
						c_q     <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						cmd_q    <= command;
						inside_q <= in_inside;
						if (command == CMD_STEP) begin
							c_q     <= '0;
							i_q     <= '0;
							j_q     <= '0;
							state_q <= S_GRD;
						end else if (command == CMD_READ) begin
							state_q <= S_RDONE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_GRD: state_q <= S_GWR;
				S_GWR: begin
					if (int'(c_q) + 1 == int'(cells)) begin
						if (sub_q == 8'd0) begin
							state_q <= S_DONE;
						end else begin
							// sweep starts at the first interior cell
							c_q     <= ADDR_W'(w) + ADDR_W'(1);
							i_q     <= DIM_W'(1);
							j_q     <= DIM_W'(1);
							n_q     <= '0;
							state_q <= S_SRD0;
						end
					end else begin
						c_q     <= c_q + ADDR_W'(1);
						state_q <= S_GRD;
						if (int'(i_q) + 1 == int'(w)) begin
							i_q <= '0;
							j_q <= j_q + DIM_W'(1);
						end else begin
							i_q <= i_q + DIM_W'(1);
						end
					end
				end
				S_SRD0: state_q <= (s != 3'd0) ? S_SRD1 : S_WR2;
				S_SRD1: begin
					cw_q    <= vrd_q;
					state_q <= S_SRD2;
				end
				S_SRD2: begin
					rw_q    <= vrd_q;
					state_q <= S_CALC;
				end
				S_CALC: begin
					uw_q  <= vrd_q;
					div_q <= 34'(signed'(rw_q[63:32])) + 34'(signed'(vrd_q[31:0]))
						- 34'(signed'(cw_q[63:32])) - 34'(signed'(cw_q[31:0]));
					state_q <= S_ABS;
				end
				S_ABS: begin
					neg_q   <= div_q[33];
					mag_q   <= div_q[33] ? MAG_W'(-35'(div_q)) : MAG_W'(div_q);
					state_q <= S_MUL0;
				end
				S_MUL0: begin
					prod_q  <= PROD_W'(relax_q * mag_q[LO_W-1:0]);
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					prod_q  <= prod_q + (PROD_W'(relax_q * mag_q[MAG_W-1:LO_W]) << LO_W);
					state_q <= S_RND;
				end
				S_RND: begin
					// round half away, then exact divide by the neighbour count
					quo_q   <= T_W'(t_sum >> FRAC_BITS);
					rem_q   <= '0;
					dcnt_q  <= DCNT_W'(T_W);
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= ge ? 3'(rsh - {1'b0, s}) : rsh[2:0];
					quo_q  <= {quo_q[T_W-2:0], ge};
					dcnt_q <= dcnt_q - DCNT_W'(1);
					if (dcnt_q == DCNT_W'(1)) state_q <= S_SAT;
				end
				S_SAT: begin
					if (neg_q)
						corr_q <= (64'(quo_q) > 64'h80000000) ? 32'sh80000000
							: -32'(quo_q);
					else
						corr_q <= (64'(quo_q) > 64'h7fffffff) ? 32'sh7fffffff
							: 32'(quo_q);
					state_q <= S_MULP;
				end
				S_MULP: begin
					pp_q    <= corr_q * $signed({1'b0, pscale_q});
					state_q <= S_PRND;
				end
				S_PRND: begin
					pq_q    <= pp_q[63] ? -$signed(pqm) : $signed(pqm);
					state_q <= S_PSUM;
				end
				S_PSUM: begin
					pnew_q  <= sat32(64'(signed'(prd_q)) + pq_q);
					state_q <= S_WR0;
				end
				S_WR0: state_q <= S_WR1;
				S_WR1: state_q <= S_WR2;
				S_WR2: begin
					// next interior cell, row or sweep
					state_q <= S_SRD0;
					if (last_col) begin
						if (last_row) begin
							if (last_sweep) begin
								state_q <= S_DONE;
							end else begin
								n_q <= n_q + 8'd1;
								c_q <= ADDR_W'(w) + ADDR_W'(1);
								i_q <= DIM_W'(1);
								j_q <= DIM_W'(1);
							end
						end else begin
							c_q <= c_q + ADDR_W'(3);
							i_q <= DIM_W'(1);
							j_q <= j_q + DIM_W'(1);
						end
					end else begin
						c_q <= c_q + ADDR_W'(1);
						i_q <= i_q + DIM_W'(1);
					end
				end
				S_RDONE, S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						done_kind <= cmd_q;
						if (state_q == S_RDONE && inside_q) begin
							u_out        <= vrd_q[63:32];
							v_out        <= vrd_q[31:0];
							pressure_out <= prd_q;
						end else begin
							u_out        <= '0;
							v_out        <= '0;
							pressure_out <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a word accepted leaves idle until its result is posted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != S_IDLE)
		else $error("accepted command did not start");

	// sweep cursor stays inside the grid in use
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRD0 || state_q == S_WR2) |-> int'(c_q) < int'(cells))
		else $error("sweep cursor outside grid");

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(done_kind) && $stable(u_out)
			&& $stable(v_out) && $stable(pressure_out))
		else $error("result word changed while stalled");

	// divide runs only on an open cell
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> s != 3'd0)
		else $error("divide by zero neighbours");

endmodule
